[rtl/lspm_pkg.sv]
`timescale 1ns / 1ps
package lspm_pkg;

  localparam int MAX_GROUP = 32;
  localparam int GRP_W     = 6;
  localparam int DIV_W     = 17;
  localparam int PROD_W    = 33;
  localparam int NCOL      = 5;
  localparam int QDEPTH    = 8;
  localparam int QAW       = 3;
  localparam int QCW       = 4;
  localparam int FCW       = 3;
  localparam int ADDR_W    = 5;

  localparam logic [GRP_W-1:0] GRP_MAX_V   = GRP_W'(MAX_GROUP);
  localparam logic [GRP_W-1:0] GRP_MIN_V   = GRP_W'(1);
  localparam logic [QCW:0]     CREDIT_LIMIT = (QCW + 1)'(QDEPTH);
  localparam logic [4:0]       DIV_STEPS   = 5'(DIV_W);

  localparam logic [2:0] REG_START_LED  = 3'd0;
  localparam logic [2:0] REG_PHYS_LEN   = 3'd1;
  localparam logic [2:0] REG_GROUPING   = 3'd2;
  localparam logic [2:0] REG_SPACING    = 3'd3;
  localparam logic [2:0] REG_ROTATE     = 3'd4;
  localparam logic [2:0] REG_BRIGHTNESS = 3'd5;
  localparam logic [2:0] REG_BAND_OFS   = 3'd6;
  localparam logic [2:0] REG_MODE       = 3'd7;

  localparam int MODE_REV    = 0;
  localparam int MODE_MIRROR = 1;
  localparam int MODE_BAND   = 2;

  localparam logic [1:0] FMT_RGB   = 2'd0;
  localparam logic [1:0] FMT_RGBW  = 2'd1;
  localparam logic [1:0] FMT_RGBWC = 2'd2;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_LEN_GO,
    CS_LEN_WAIT,
    CS_ROT_GO,
    CS_ROT_WAIT
  } cfg_state_t;

  typedef struct packed {
    logic [15:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  white_warm;
    logic [7:0]  white_cool;
    logic [1:0]  channel_format;
  } in_word_t;

  typedef struct packed {
    logic [15:0] led_index;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_white_warm;
    logic [7:0]  out_white_cool;
    logic [1:0]  out_format;
    logic        write_valid;
    logic        accepted;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [15:0]      start_led;
    logic [15:0]      phys_len;
    logic [GRP_W-1:0] grouping;
    logic [DIV_W-1:0] step;
    logic             plain;
    logic [15:0]      rot_mod;
    logic [7:0]       brightness;
    logic [15:0]      band_offset;
    logic [2:0]       mode;
    logic [15:0]      log_len;
  } cfg_t;

  typedef struct packed {
    logic [NCOL-1:0][7:0]   col;
    logic [1:0]             fmt;
    logic                   accepted;
    logic [1:0][15:0]       base;
    logic [1:0][GRP_W-1:0]  cnt;
  } job_t;

endpackage

[rtl/lspm_div.sv]
`timescale 1ns / 1ps
module lspm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lspm_pkg::DIV_W-1:0] num,
  input  logic [lspm_pkg::DIV_W-1:0] den,
  output logic                       done,
  output logic [lspm_pkg::DIV_W-1:0] quo,
  output logic [lspm_pkg::DIV_W-1:0] rem
);

  logic [lspm_pkg::DIV_W-1:0] den_r;
  logic [lspm_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [lspm_pkg::DIV_W-1:0] rem_r, rem_nxt;
  logic [4:0]                 cnt_r;
  logic                       run_r;
  logic                       done_r;
  logic [lspm_pkg::DIV_W:0]   trial;
  logic [lspm_pkg::DIV_W:0]   diff;
  logic                       fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, quo_r[lspm_pkg::DIV_W-1]};
    diff    = trial - {1'b0, den_r};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? diff[lspm_pkg::DIV_W-1:0] : trial[lspm_pkg::DIV_W-1:0];
    quo_nxt = {quo_r[lspm_pkg::DIV_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= lspm_pkg::DIV_STEPS;
    end else if (run_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      quo_r <= num;
      rem_r <= '0;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

[rtl/lspm_cfg.sv]
`timescale 1ns / 1ps
module lspm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lspm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output lspm_pkg::cfg_t              cfg,
  output logic                        busy
);

  logic [15:0]                start_led_r;
  logic [15:0]                phys_len_r;
  logic [lspm_pkg::GRP_W-1:0] grouping_r;
  logic [15:0]                spacing_r;
  logic [15:0]                rotate_r;
  logic [7:0]                 brightness_r;
  logic [15:0]                band_ofs_r;
  logic [2:0]                 mode_r;
  logic [15:0]                log_len_r, log_len_nxt;
  logic [15:0]                rot_mod_r;

  lspm_pkg::cfg_state_t       state_r, state_nxt;

  logic                       wr;
  logic [2:0]                 widx;
  logic [lspm_pkg::GRP_W-1:0] grp_wr;
  logic                       recalc;
  logic                       plain;
  logic [lspm_pkg::DIV_W-1:0] step;

  logic                       div_start;
  logic [lspm_pkg::DIV_W-1:0] div_num;
  logic [lspm_pkg::DIV_W-1:0] div_den;
  logic                       div_done;
  logic [lspm_pkg::DIV_W-1:0] div_quo;
  logic [lspm_pkg::DIV_W-1:0] div_rem;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = paddr[lspm_pkg::ADDR_W-1:2];
  assign plain  = (grouping_r == lspm_pkg::GRP_MIN_V) && (spacing_r == 16'd0);
  assign step   = {11'd0, grouping_r} + {1'b0, spacing_r};

  always_comb begin
    if (pwdata[lspm_pkg::GRP_W-1:0] == '0) begin
      grp_wr = lspm_pkg::GRP_MIN_V;
    end else if (pwdata[lspm_pkg::GRP_W-1:0] > lspm_pkg::GRP_MAX_V) begin
      grp_wr = lspm_pkg::GRP_MAX_V;
    end else begin
      grp_wr = pwdata[lspm_pkg::GRP_W-1:0];
    end
  end

  assign recalc = wr && ((widx == lspm_pkg::REG_PHYS_LEN) || (widx == lspm_pkg::REG_GROUPING) ||
                         (widx == lspm_pkg::REG_SPACING) || (widx == lspm_pkg::REG_ROTATE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_led_r  <= 16'd0;
      phys_len_r   <= 16'd1;
      grouping_r   <= lspm_pkg::GRP_MIN_V;
      spacing_r    <= 16'd0;
      rotate_r     <= 16'd0;
      brightness_r <= 8'hFF;
      band_ofs_r   <= 16'd0;
      mode_r       <= 3'd0;
    end else if (wr) begin
      case (widx)
        lspm_pkg::REG_START_LED:  start_led_r  <= pwdata[15:0];
        lspm_pkg::REG_PHYS_LEN:   phys_len_r   <= pwdata[15:0];
        lspm_pkg::REG_GROUPING:   grouping_r   <= grp_wr;
        lspm_pkg::REG_SPACING:    spacing_r    <= pwdata[15:0];
        lspm_pkg::REG_ROTATE:     rotate_r     <= pwdata[15:0];
        lspm_pkg::REG_BRIGHTNESS: brightness_r <= pwdata[7:0];
        lspm_pkg::REG_BAND_OFS:   band_ofs_r   <= pwdata[15:0];
        lspm_pkg::REG_MODE:       mode_r       <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      lspm_pkg::REG_START_LED:  prdata = {16'd0, start_led_r};
      lspm_pkg::REG_PHYS_LEN:   prdata = {16'd0, phys_len_r};
      lspm_pkg::REG_GROUPING:   prdata = {26'd0, grouping_r};
      lspm_pkg::REG_SPACING:    prdata = {16'd0, spacing_r};
      lspm_pkg::REG_ROTATE:     prdata = {16'd0, rotate_r};
      lspm_pkg::REG_BRIGHTNESS: prdata = {24'd0, brightness_r};
      lspm_pkg::REG_BAND_OFS:   prdata = {16'd0, band_ofs_r};
      lspm_pkg::REG_MODE:       prdata = {29'd0, mode_r};
      default:                  prdata = '0;
    endcase
  end

  // a write to any length-related register restarts both divisions
  always_comb begin
    if (recalc) begin
      state_nxt = lspm_pkg::CS_LEN_GO;
    end else begin
      case (state_r)
        lspm_pkg::CS_IDLE:     state_nxt = lspm_pkg::CS_IDLE;
        lspm_pkg::CS_LEN_GO:   state_nxt = lspm_pkg::CS_LEN_WAIT;
        lspm_pkg::CS_LEN_WAIT: state_nxt = div_done ? lspm_pkg::CS_ROT_GO : lspm_pkg::CS_LEN_WAIT;
        lspm_pkg::CS_ROT_GO:   state_nxt = lspm_pkg::CS_ROT_WAIT;
        lspm_pkg::CS_ROT_WAIT: state_nxt = div_done ? lspm_pkg::CS_IDLE : lspm_pkg::CS_ROT_WAIT;
        default:               state_nxt = lspm_pkg::CS_IDLE;
      endcase
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = {1'b0, phys_len_r} + {1'b0, spacing_r};
    div_den   = step;
    busy      = 1'b1;
    case (state_r)
      lspm_pkg::CS_IDLE: begin
        busy = 1'b0;
      end
      lspm_pkg::CS_LEN_GO: begin
        div_start = 1'b1;
      end
      lspm_pkg::CS_ROT_GO: begin
        div_start = 1'b1;
        div_num   = {1'b0, rotate_r};
        div_den   = {1'b0, phys_len_r};
      end
      lspm_pkg::CS_ROT_WAIT: begin
        div_num   = {1'b0, rotate_r};
        div_den   = {1'b0, phys_len_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    if (plain) begin
      log_len_nxt = phys_len_r;
    end else if (div_quo[lspm_pkg::DIV_W-1]) begin
      log_len_nxt = 16'hFFFF;
    end else if (div_quo == '0) begin
      log_len_nxt = 16'd1;
    end else begin
      log_len_nxt = div_quo[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lspm_pkg::CS_IDLE;
      log_len_r <= 16'd1;
      rot_mod_r <= 16'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == lspm_pkg::CS_LEN_WAIT && div_done) begin
        log_len_r <= log_len_nxt;
      end
      if (state_r == lspm_pkg::CS_ROT_WAIT && div_done) begin
        rot_mod_r <= div_rem[15:0];
      end
    end
  end

  lspm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_comb begin
    cfg.start_led   = start_led_r;
    cfg.phys_len    = phys_len_r;
    cfg.grouping    = grouping_r;
    cfg.step        = step;
    cfg.plain       = plain;
    cfg.rot_mod     = rot_mod_r;
    cfg.brightness  = brightness_r;
    cfg.band_offset = band_ofs_r;
    cfg.mode        = mode_r;
    cfg.log_len     = log_len_r;
  end

endmodule

[rtl/lspm_front.sv]
`timescale 1ns / 1ps
module lspm_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  lspm_pkg::in_word_t       in_data,
  output logic                     in_stall,
  input  lspm_pkg::cfg_t           cfg,
  input  logic                     cfg_busy,
  input  logic [lspm_pkg::QCW-1:0] q_count,
  output logic                     push,
  output lspm_pkg::job_t           job
);

  typedef struct packed {
    logic [15:0]                    idx;
    logic                           ok;
    logic [1:0]                     fmt;
    logic [lspm_pkg::NCOL-1:0][15:0] prod;
  } s1_t;

  typedef struct packed {
    logic [15:0]                   mapped;
    logic [15:0]                   mir;
    logic                          ok;
    logic                          mir_en;
    logic [1:0]                    fmt;
    logic [lspm_pkg::NCOL-1:0][7:0] col;
  } s2_t;

  typedef struct packed {
    logic [1:0][lspm_pkg::PROD_W-1:0] m;
    logic                             ok;
    logic                             mir_en;
    logic [1:0]                       fmt;
    logic [lspm_pkg::NCOL-1:0][7:0]   col;
  } s3_t;

  typedef struct packed {
    logic [1:0][15:0]              pos;
    logic [1:0]                    past;
    logic                          ok;
    logic                          mir_en;
    logic [1:0]                    fmt;
    logic [lspm_pkg::NCOL-1:0][7:0] col;
  } s4_t;

  logic v1_r, v2_r, v3_r, v4_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;

  logic [lspm_pkg::FCW-1:0]        inflight;
  logic [lspm_pkg::QCW:0]          used;
  logic                            accept;
  logic [15:0]                     idx_off;
  logic [1:0]                      fmt_c;
  logic [lspm_pkg::NCOL-1:0][7:0]  col_in;
  logic [15:0]                     rev_idx;
  logic [1:0][lspm_pkg::DIV_W-1:0] rsum;
  logic [1:0][lspm_pkg::DIV_W-1:0] rsub;
  logic [1:0][15:0]                left;
  logic [1:0][lspm_pkg::GRP_W-1:0] grp_cnt;

  // (c*br+127)/255: take x>>8, remainder stays below 2*255
  function automatic logic [7:0] scale8(input logic [15:0] p);
    logic [15:0] x;
    logic [7:0]  q0;
    logic [8:0]  r;
    x  = p + 16'd127;
    q0 = x[15:8];
    r  = {1'b0, x[7:0]} + {1'b0, q0};
    return (r >= 9'd255) ? q0 + 8'd1 : q0;
  endfunction

  assign inflight = {2'b0, v1_r} + {2'b0, v2_r} + {2'b0, v3_r} + {2'b0, v4_r};
  assign used     = {1'b0, q_count} + {2'b0, inflight};
  assign in_stall = cfg_busy || (used >= lspm_pkg::CREDIT_LIMIT);
  assign accept   = in_valid && !in_stall;

  // stage 1: window check, brightness products
  always_comb begin
    idx_off = in_data.pixel_index - cfg.band_offset;
    fmt_c   = (in_data.channel_format > lspm_pkg::FMT_RGBWC) ? lspm_pkg::FMT_RGBWC
                                                             : in_data.channel_format;
    col_in[0] = in_data.red;
    col_in[1] = in_data.green;
    col_in[2] = in_data.blue;
    col_in[3] = (fmt_c != lspm_pkg::FMT_RGB) ? in_data.white_warm : 8'd0;
    col_in[4] = (fmt_c == lspm_pkg::FMT_RGBWC) ? in_data.white_cool : 8'd0;
    s1_nxt.fmt = fmt_c;
    if (cfg.mode[lspm_pkg::MODE_BAND]) begin
      s1_nxt.ok  = (in_data.pixel_index >= cfg.band_offset) && (idx_off < cfg.log_len);
      s1_nxt.idx = idx_off;
    end else begin
      s1_nxt.ok  = in_data.pixel_index < cfg.log_len;
      s1_nxt.idx = in_data.pixel_index;
    end
    for (int k = 0; k < lspm_pkg::NCOL; k++) begin
      s1_nxt.prod[k] = {8'd0, col_in[k]} * {8'd0, cfg.brightness};
    end
  end

  // stage 2: scaled colors, reversed and mirrored index
  always_comb begin
    rev_idx       = cfg.log_len - 16'd1 - s1_r.idx;
    s2_nxt.ok     = s1_r.ok;
    s2_nxt.fmt    = s1_r.fmt;
    s2_nxt.mapped = cfg.mode[lspm_pkg::MODE_REV] ? rev_idx : s1_r.idx;
    s2_nxt.mir    = cfg.mode[lspm_pkg::MODE_REV] ? s1_r.idx : rev_idx;
    s2_nxt.mir_en = s1_r.ok && cfg.mode[lspm_pkg::MODE_MIRROR] && (cfg.log_len > 16'd1) &&
                    (rev_idx != s1_r.idx);
    for (int k = 0; k < lspm_pkg::NCOL; k++) begin
      s2_nxt.col[k] = scale8(s1_r.prod[k]);
    end
  end

  // stage 3: index times group pitch
  always_comb begin
    s3_nxt.ok     = s2_r.ok;
    s3_nxt.mir_en = s2_r.mir_en;
    s3_nxt.fmt    = s2_r.fmt;
    s3_nxt.col    = s2_r.col;
    if (cfg.plain) begin
      s3_nxt.m[0] = {17'd0, s2_r.mapped};
      s3_nxt.m[1] = {17'd0, s2_r.mir};
    end else begin
      s3_nxt.m[0] = {17'd0, s2_r.mapped} * {16'd0, cfg.step};
      s3_nxt.m[1] = {17'd0, s2_r.mir} * {16'd0, cfg.step};
    end
  end

  // stage 4: past-end check and rotation
  always_comb begin
    s4_nxt.ok     = s3_r.ok;
    s4_nxt.mir_en = s3_r.mir_en;
    s4_nxt.fmt    = s3_r.fmt;
    s4_nxt.col    = s3_r.col;
    for (int k = 0; k < 2; k++) begin
      s4_nxt.past[k] = s3_r.m[k] >= {17'd0, cfg.phys_len};
      rsum[k]        = {1'b0, s3_r.m[k][15:0]} + {1'b0, cfg.rot_mod};
      rsub[k]        = rsum[k] - {1'b0, cfg.phys_len};
      s4_nxt.pos[k]  = (rsum[k] >= {1'b0, cfg.phys_len}) ? rsub[k][15:0] : rsum[k][15:0];
    end
  end

  // queue entry: group lengths and strip base indices
  always_comb begin
    job.col      = s4_r.col;
    job.fmt      = s4_r.fmt;
    job.accepted = s4_r.ok;
    for (int k = 0; k < 2; k++) begin
      left[k]     = cfg.phys_len - s4_r.pos[k];
      grp_cnt[k]  = (left[k] < {10'd0, cfg.grouping}) ? left[k][lspm_pkg::GRP_W-1:0]
                                                      : cfg.grouping;
      job.base[k] = cfg.start_led + s4_r.pos[k];
    end
    job.cnt[0] = (s4_r.ok && !s4_r.past[0]) ? grp_cnt[0] : '0;
    job.cnt[1] = (s4_r.mir_en && !s4_r.past[1]) ? grp_cnt[1] : '0;
  end

  assign push = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
    s4_r <= s4_nxt;
  end

endmodule

[rtl/lspm_queue.sv]
`timescale 1ns / 1ps
module lspm_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  lspm_pkg::job_t           wdata,
  input  logic                     pop,
  output lspm_pkg::job_t           rdata,
  output logic [lspm_pkg::QCW-1:0] count
);

  lspm_pkg::job_t             mem_r [lspm_pkg::QDEPTH];
  logic [lspm_pkg::QAW-1:0]   wptr_r, rptr_r;
  logic [lspm_pkg::QCW-1:0]   count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rptr_r];
  assign count = count_r;

endmodule

[rtl/lspm_back.sv]
`timescale 1ns / 1ps
module lspm_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lspm_pkg::job_t           head,
  input  logic [lspm_pkg::QCW-1:0] q_count,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output lspm_pkg::out_word_t      out_data
);

  logic                       out_valid_r, out_valid_nxt;
  lspm_pkg::out_word_t        out_r;
  lspm_pkg::out_word_t        word;
  logic [4:0]                 g_r, g_nxt;
  logic                       grp_r, grp_nxt;
  logic                       q_nonempty;
  logic                       load;
  logic                       nonwrite;
  logic                       cur;
  logic [lspm_pkg::GRP_W-1:0] cnt_cur;
  logic                       end_grp;
  logic                       last;

  assign q_nonempty = q_count != '0;
  assign load       = q_nonempty && (!out_valid_r || !out_stall);
  assign pop        = load && last;

  always_comb begin
    nonwrite = (head.cnt[0] == '0) && (head.cnt[1] == '0);
    cur      = grp_r || (head.cnt[0] == '0);
    cnt_cur  = head.cnt[cur];
    end_grp  = ({1'b0, g_r} == cnt_cur - 6'd1);
    last     = nonwrite || (end_grp && (cur || (head.cnt[1] == '0)));

    word.led_index      = nonwrite ? 16'd0 : head.base[cur] + {11'd0, g_r};
    word.out_red        = nonwrite ? 8'd0 : head.col[0];
    word.out_green      = nonwrite ? 8'd0 : head.col[1];
    word.out_blue       = nonwrite ? 8'd0 : head.col[2];
    word.out_white_warm = nonwrite ? 8'd0 : head.col[3];
    word.out_white_cool = nonwrite ? 8'd0 : head.col[4];
    word.out_format     = head.fmt;
    word.write_valid    = !nonwrite;
    word.accepted       = head.accepted;
    word.last           = last;
  end

  always_comb begin
    g_nxt   = g_r;
    grp_nxt = grp_r;
    if (load) begin
      if (last) begin
        g_nxt   = '0;
        grp_nxt = 1'b0;
      end else if (end_grp) begin
        g_nxt   = '0;
        grp_nxt = 1'b1;
      end else begin
        g_nxt = g_r + 5'd1;
      end
    end
    out_valid_nxt = out_valid_r;
    if (!out_valid_r || !out_stall) begin
      out_valid_nxt = q_nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      g_r         <= '0;
      grp_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      g_r         <= g_nxt;
      grp_r       <= grp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/led_segment_pixel_mapper_core.sv]
`timescale 1ns / 1ps
// channel   dir  handshake                          word
// in_       in   in_valid / in_stall                lspm_pkg::in_word_t
// out_      out  out_valid / out_stall              lspm_pkg::out_word_t
// cfg_      in   cfg_psel, cfg_penable, cfg_pready  32-bit registers at 4*index
//
// One word in per cycle while in_stall is low; each word yields 1 to 64 output words,
// one per cycle from the emit sequencer while out_stall is low.
// From input accept to the first output word a word passes the 4 front stages,
// the queue write and the output register.
// Writing physical_length, grouping, spacing or rotate_offset runs two divisions;
// in_stall stays high after the write until both divisions have finished.
// rst_n is synchronous; registers return to their reset values, queue empties.
// out_stall holds the output register; the 8-entry queue absorbs backpressure.
module led_segment_pixel_mapper_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lspm_pkg::in_word_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lspm_pkg::out_word_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lspm_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  lspm_pkg::cfg_t           cfg;
  logic                     cfg_busy;
  logic                     push;
  lspm_pkg::job_t           job;
  logic                     pop;
  lspm_pkg::job_t           head;
  logic [lspm_pkg::QCW-1:0] q_count;

  lspm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg),
    .busy    (cfg_busy)
  );

  lspm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .cfg      (cfg),
    .cfg_busy (cfg_busy),
    .q_count  (q_count),
    .push     (push),
    .job      (job)
  );

  lspm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (job),
    .pop   (pop),
    .rdata (head),
    .count (q_count)
  );

  lspm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_count   (q_count),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
